/* rtl/core/pms24n_pkg.sv */
// Shared types, constants and the exp(-x) interpolation table for the
// 24-neighbour Potts Metropolis site pipeline. No dependencies.
package pms24n_pkg;

  localparam int SPIN_BITS   = 8;
  localparam int SLOT_BITS   = 8;
  localparam int NEIGHBOURS  = 24;
  localparam int WIN_BITS    = NEIGHBOURS * SLOT_BITS;
  localparam int CNT_BITS    = 5;
  localparam int TAB_NODES   = 257;
  localparam int STEP_BITS   = 13;
  localparam int X_BITS      = 24;
  localparam int IDX_BITS    = 8;
  localparam int NODE_BITS   = 9;
  localparam int PROB_BITS   = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CNT_BITS-1:0] MASK_LIMIT = 5'd12;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_SPINS   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_TEMP    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_TEMP   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASK_ENABLE = 2'd3;

  typedef struct packed {
    logic [7:0]        num_spins;
    logic [X_BITS-1:0] inv_temp;
    logic              zero_temp;
    logic              mask_en;
  } cfg_t;

  typedef struct packed {
    logic [7:0]           center_spin;
    logic [WIN_BITS-1:0]  window;
    logic [15:0]          proposal_random;
    logic [PROB_BITS-1:0] acceptance_random;
  } item_t;

  // Trial after both neighbour counts are known
  typedef struct packed {
    logic [SPIN_BITS-1:0] old_spin;
    logic [SPIN_BITS-1:0] prop_spin;
    logic [CNT_BITS-1:0]  e_before;
    logic [CNT_BITS-1:0]  e_prop;
    logic [PROB_BITS-1:0] u;
  } trial_t;

  typedef struct packed {
    logic [7:0]          new_spin;
    logic                spin_changed;
    logic [CNT_BITS-1:0] energy_before;
    logic [CNT_BITS-1:0] energy_proposed;
    logic                mark_site_inactive;
    logic                clear_neighbour_marks;
  } result_t;

  typedef logic [PROB_BITS-1:0] exp_tab_t [0:TAB_NODES-1];

  // Node k holds exp(-k/8) in Q0.32, built from a Q0.63 power chain.
  function automatic exp_tab_t build_exp_tab();
    logic [63:0]  term;
    logic [63:0]  pos;
    logic [63:0]  neg;
    logic [63:0]  e;
    logic [63:0]  q;
    logic [63:0]  rem;
    logic [63:0]  quo;
    logic [63:0]  den;
    logic [127:0] prod;
    exp_tab_t     tab;
    term = 64'h8000_0000_0000_0000;
    pos  = term;
    neg  = 64'd0;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        den = 64'(8 * n);
        rem = 64'd0;
        quo = 64'd0;
        for (int b = 63; b >= 0; b--) begin
          rem = {rem[62:0], term[b]};
          if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
          end
        end
        term = quo;
        if ((n & 1) == 0) pos = pos + term;
        else              neg = neg + term;
      end
    end
    e = pos - neg;
    q = 64'h8000_0000_0000_0000;
    tab[0] = 32'hFFFF_FFFF;
    for (int k = 1; k < TAB_NODES; k++) begin
      prod   = {64'd0, q} * {64'd0, e};
      q      = prod[126:63];
      tab[k] = PROB_BITS'((q + 64'h4000_0000) >> 31);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* rtl/core/pms24n_front.sv */
// Front of the site pipeline: proposal spin and both unlike-neighbour counts.
// Two register stages. Depends on pms24n_pkg.
module pms24n_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pms24n_pkg::cfg_t     cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pms24n_pkg::item_t    up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pms24n_pkg::trial_t   dn_trial
);

  localparam int SPIN_BITS_L = pms24n_pkg::SPIN_BITS;

  typedef struct packed {
    logic [SPIN_BITS_L-1:0]              old_spin;
    logic [SPIN_BITS_L-1:0]              prop_spin;
    logic [pms24n_pkg::CNT_BITS-1:0]     e_before;
    logic [pms24n_pkg::WIN_BITS-1:0]     window;
    logic [pms24n_pkg::PROB_BITS-1:0]    u;
  } stage_a_t;

  function automatic logic [pms24n_pkg::CNT_BITS-1:0] unlike_count(
      input logic [pms24n_pkg::WIN_BITS-1:0] win,
      input logic [SPIN_BITS_L-1:0]          spin);
    logic [pms24n_pkg::CNT_BITS-1:0] cnt;
    cnt = '0;
    for (int k = 0; k < pms24n_pkg::NEIGHBOURS; k++) begin
      if (win[k*pms24n_pkg::SLOT_BITS +: SPIN_BITS_L] != spin)
        cnt = cnt + pms24n_pkg::CNT_BITS'(1);
    end
    return cnt;
  endfunction

  logic     a_valid_r;
  stage_a_t a_r;
  stage_a_t a_nxt;
  logic     a_ready;
  logic     b_valid_r;
  pms24n_pkg::trial_t b_r;
  pms24n_pkg::trial_t b_nxt;

  logic [23:0] prop_prod;
  logic [8:0]  prop_sum;
  logic [8:0]  prop_clamp;

  // Stage A: proposal and count for the current spin
  always_comb begin
    prop_prod  = {8'd0, up_item.proposal_random} * {16'd0, cfg.num_spins};
    prop_sum   = {1'b0, prop_prod[23:16]} + 9'd1;
    prop_clamp = (prop_sum > {1'b0, cfg.num_spins}) ? {1'b0, cfg.num_spins} : prop_sum;
    a_nxt.old_spin  = up_item.center_spin[SPIN_BITS_L-1:0];
    a_nxt.prop_spin = prop_clamp[SPIN_BITS_L-1:0];
    a_nxt.e_before  = unlike_count(up_item.window, up_item.center_spin[SPIN_BITS_L-1:0]);
    a_nxt.window    = up_item.window;
    a_nxt.u         = up_item.acceptance_random;
  end

  // Stage B: count for the proposed spin
  always_comb begin
    b_nxt.old_spin  = a_r.old_spin;
    b_nxt.prop_spin = a_r.prop_spin;
    b_nxt.e_before  = a_r.e_before;
    b_nxt.e_prop    = unlike_count(a_r.window, a_r.prop_spin);
    b_nxt.u         = a_r.u;
  end

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (up_ready) a_valid_r <= up_valid;
      if (a_ready)  b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) a_r <= a_nxt;
    if (a_ready && a_valid_r) b_r <= b_nxt;
  end

  assign dn_valid = b_valid_r;
  assign dn_trial = b_r;

endmodule

/* rtl/core/pms24n_accept.sv */
// Acceptance part of the site pipeline: Boltzmann weight from the exp table
// with interpolation, the decision and the result register. Depends on pms24n_pkg.
module pms24n_accept (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pms24n_pkg::cfg_t      cfg,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  pms24n_pkg::trial_t    up_trial,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output pms24n_pkg::result_t   dn_result
);

  typedef struct packed {
    pms24n_pkg::trial_t                trial;
    logic                              uphill;
    logic [pms24n_pkg::X_BITS-1:0]     x;
  } stage_c_t;

  typedef struct packed {
    pms24n_pkg::trial_t                 trial;
    logic                               uphill;
    logic                               beyond;
    logic [pms24n_pkg::PROB_BITS-1:0]   t_lo;
    logic [pms24n_pkg::PROB_BITS-1:0]   t_diff;
    logic [pms24n_pkg::STEP_BITS-1:0]   frac;
  } stage_d_t;

  localparam int PROD_BITS = pms24n_pkg::PROB_BITS + pms24n_pkg::STEP_BITS;

  logic     c_valid_r;
  stage_c_t c_r;
  stage_c_t c_nxt;
  logic     c_ready;
  logic     d_valid_r;
  stage_d_t d_r;
  stage_d_t d_nxt;
  logic     d_ready;
  logic     e_valid_r;
  pms24n_pkg::result_t e_r;
  pms24n_pkg::result_t e_nxt;

  logic [pms24n_pkg::CNT_BITS-1:0]  delta;
  logic [28:0]                      x_full;
  logic [pms24n_pkg::IDX_BITS-1:0]  idx;
  logic [pms24n_pkg::NODE_BITS-1:0] node_lo;
  logic [pms24n_pkg::NODE_BITS-1:0] node_hi;
  logic [PROD_BITS-1:0]             interp;
  logic [pms24n_pkg::PROB_BITS-1:0] weight;
  logic                             accept;
  logic [pms24n_pkg::SPIN_BITS-1:0] next_spin;

  // Stage C: scaled energy rise, saturated to Q8.16
  always_comb begin
    delta        = up_trial.e_prop - up_trial.e_before;
    x_full       = {24'd0, delta} * {5'd0, cfg.inv_temp};
    c_nxt.trial  = up_trial;
    c_nxt.uphill = up_trial.e_prop > up_trial.e_before;
    c_nxt.x      = (x_full[28:24] != 5'd0) ? {pms24n_pkg::X_BITS{1'b1}}
                                           : x_full[pms24n_pkg::X_BITS-1:0];
  end

  // Stage D: fetch the two table nodes around x
  always_comb begin
    idx     = c_r.x[pms24n_pkg::STEP_BITS +: pms24n_pkg::IDX_BITS];
    node_lo = {1'b0, idx};
    node_hi = {1'b0, idx} + 9'd1;
    d_nxt.trial  = c_r.trial;
    d_nxt.uphill = c_r.uphill;
    d_nxt.beyond = c_r.x[pms24n_pkg::X_BITS-1:pms24n_pkg::STEP_BITS+pms24n_pkg::IDX_BITS]
                   != '0;
    d_nxt.t_lo   = pms24n_pkg::EXP_TAB[node_lo];
    d_nxt.t_diff = pms24n_pkg::EXP_TAB[node_lo] - pms24n_pkg::EXP_TAB[node_hi];
    d_nxt.frac   = c_r.x[pms24n_pkg::STEP_BITS-1:0];
  end

  // Stage E: interpolate, compare, build the result
  always_comb begin
    interp    = {{pms24n_pkg::STEP_BITS{1'b0}}, d_r.t_diff} *
                {{pms24n_pkg::PROB_BITS{1'b0}}, d_r.frac};
    weight    = d_r.beyond ? '0
              : d_r.t_lo - interp[pms24n_pkg::STEP_BITS +: pms24n_pkg::PROB_BITS];
    accept    = !d_r.uphill || (!cfg.zero_temp && (d_r.trial.u <= weight));
    next_spin = accept ? d_r.trial.prop_spin : d_r.trial.old_spin;
    e_nxt.new_spin              = 8'(next_spin);
    e_nxt.spin_changed          = next_spin != d_r.trial.old_spin;
    e_nxt.energy_before         = d_r.trial.e_before;
    e_nxt.energy_proposed       = d_r.trial.e_prop;
    e_nxt.mark_site_inactive    = cfg.mask_en && (d_r.trial.e_before < pms24n_pkg::MASK_LIMIT);
    e_nxt.clear_neighbour_marks = cfg.mask_en && (next_spin != d_r.trial.old_spin);
  end

  assign d_ready  = !e_valid_r || dn_ready;
  assign c_ready  = !d_valid_r || d_ready;
  assign up_ready = !c_valid_r || c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      if (up_ready) c_valid_r <= up_valid;
      if (c_ready)  d_valid_r <= c_valid_r;
      if (d_ready)  e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) c_r <= c_nxt;
    if (c_ready && c_valid_r) d_r <= d_nxt;
    if (d_ready && d_valid_r) e_r <= e_nxt;
  end

  assign dn_valid  = e_valid_r;
  assign dn_result = e_r;

endmodule

/* rtl/core/potts_metropolis_site_step_24n_core.sv */
// Top level of the 24-neighbour Potts Metropolis site step.
// Holds the configuration registers; instantiates pms24n_front and pms24n_accept.
// Depends on pms24n_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one site trial per transaction, the
//   centre spin, the 24 window spins in three 64-bit words and two random words.
//   Output channel (out_valid/out_ready): one result transaction per input.
//   Configuration: write cfg_wdata to register cfg_index while cfg_we is high;
//   write only while no trial is in flight.
// Pipeline: five register stages (proposal/first count, second count, scaled
//   energy rise, table fetch, interpolation and decision).
// Throughput: one trial per cycle while out_ready is high.
// Reset (rst_n low, synchronous): the pipeline empties and the registers take
//   num_spins 2, inverse temperature 1.0, finite temperature, masking off.
// Stall: with out_ready low the result holds; earlier stages keep filling their
//   empty slots and in_ready falls once all five stages hold a trial.
module potts_metropolis_site_step_24n_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_center_spin,
  input  logic [63:0] in_neighbours_rows_top,
  input  logic [63:0] in_neighbours_middle,
  input  logic [63:0] in_neighbours_rows_bottom,
  input  logic [15:0] in_proposal_random,
  input  logic [31:0] in_acceptance_random,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_new_spin,
  output logic        out_spin_changed,
  output logic [4:0]  out_energy_before,
  output logic [4:0]  out_energy_proposed,
  output logic        out_mark_site_inactive,
  output logic        out_clear_neighbour_marks,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  pms24n_pkg::cfg_t    cfg_r;
  pms24n_pkg::item_t   item;
  pms24n_pkg::trial_t  trial;
  pms24n_pkg::result_t result;
  logic                mid_valid;
  logic                mid_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_spins <= 8'd2;
      cfg_r.inv_temp  <= 24'd65536;
      cfg_r.zero_temp <= 1'b0;
      cfg_r.mask_en   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pms24n_pkg::REG_NUM_SPINS:   cfg_r.num_spins <= cfg_wdata[7:0];
        pms24n_pkg::REG_INV_TEMP:    cfg_r.inv_temp  <= cfg_wdata;
        pms24n_pkg::REG_ZERO_TEMP:   cfg_r.zero_temp <= cfg_wdata[0];
        pms24n_pkg::REG_MASK_ENABLE: cfg_r.mask_en   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign item.center_spin       = in_center_spin;
  assign item.window            = {in_neighbours_rows_bottom, in_neighbours_middle,
                                   in_neighbours_rows_top};
  assign item.proposal_random   = in_proposal_random;
  assign item.acceptance_random = in_acceptance_random;

  pms24n_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (item),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_trial (trial)
  );

  pms24n_accept u_accept (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_trial  (trial),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .dn_result (result)
  );

  assign out_new_spin              = result.new_spin;
  assign out_spin_changed          = result.spin_changed;
  assign out_energy_before         = result.energy_before;
  assign out_energy_proposed       = result.energy_proposed;
  assign out_mark_site_inactive    = result.mark_site_inactive;
  assign out_clear_neighbour_marks = result.clear_neighbour_marks;

  // A downhill proposal differs from the old spin and is always taken
  a_downhill_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_energy_proposed < out_energy_before) |-> out_spin_changed)
    else $error("downhill proposal not accepted");

  a_clear_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clear_neighbour_marks |-> out_spin_changed)
    else $error("neighbour clear without spin change");

  a_inactive_low_energy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mark_site_inactive |-> (out_energy_before < 5'd12))
    else $error("inactive mark with high energy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_energy_before <= 5'd24) && (out_energy_proposed <= 5'd24))
    else $error("neighbour count out of range");

endmodule
